/* hw/rtl/assert_macros.svh */
// Assertion macros for the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define QMR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property violated");

// Same, for an implication written by the caller as antecedent and consequent.
`define QMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: implication violated");

`endif

/* hw/rtl/qmr_pkg.sv */
// Shared types, constants and term tables for the quaternion multiply/rotate unit.
package qmr_pkg;

  localparam int COMP_W    = 32;
  localparam int FRAC_BITS = 16;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t COMP_MAX = 32'sh7fff_ffff;
  localparam comp_t COMP_MIN = 32'sh8000_0000;

  // Hamilton product r = a * b, components ordered x, y, z, w.
  // Row i is the result component, column j the a component; BSEL picks the
  // b component it pairs with, BNEG marks a subtracted term.
  localparam logic [1:0] BSEL [4][4] = '{
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  localparam logic BNEG [4][4] = '{
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0}
  };

endpackage

/* hw/rtl/quaternion_multiply_rotate_unit.sv */
// Top level: pipelined quaternion product and vector rotation, signed fixed point.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries func_i plus two quaternions.
//   func_i = 0 returns first * second (Hamilton product).
//   func_i = 1 rotates vector (second_x/y/z) by first: first * v * conj(first);
//   out_w_o is zero for rotation.
//   Each product is floored by an arithmetic shift of FracBits (8..24), each
//   four-term sum saturates to 32 bits, and the rotation intermediate is
//   saturated before the second pass.
// Timing:
//   Four register stages: two for the first product pass, two for the second.
//   An accepted item moves through pass one and then pass two to out_valid_o. One item
//   per cycle sustained while the receiver does not stall; the rate is set by
//   the 16-multiplier array in each pass, which takes a new operand set every cycle.
//   The product pass for func_i = 0 multiplies by the identity in pass two.
// Reset: rst_ni clears all valid bits; no result is pending afterwards.
// Stall: when out_valid_o is high and out_ready_i low, the whole pipe holds,
//   in_ready_o drops, and the presented result stays put until its transfer.
module quaternion_multiply_rotate_unit #(
  parameter int FracBits = qmr_pkg::FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic signed [31:0]    first_x_i,
  input  logic signed [31:0]    first_y_i,
  input  logic signed [31:0]    first_z_i,
  input  logic signed [31:0]    first_w_i,
  input  logic signed [31:0]    second_x_i,
  input  logic signed [31:0]    second_y_i,
  input  logic signed [31:0]    second_z_i,
  input  logic signed [31:0]    second_w_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o,
  output logic signed [31:0]    out_z_o,
  output logic signed [31:0]    out_w_o
);

  // conjugate needs one extra bit: -(-2^31) must stay exact
  localparam int CW = qmr_pkg::COMP_W + 1;
  localparam logic signed [CW-1:0] One = CW'(1) <<< FracBits;

  logic                  en;
  logic                  in_xfer;
  logic                  v_mid;
  qmr_pkg::comp_t        a_in  [4];
  qmr_pkg::comp_t        b_in  [4];
  qmr_pkg::comp_t        t_mid [4];
  qmr_pkg::comp_t        r_out [4];
  logic signed [CW-1:0]  c_d   [4];
  logic signed [CW-1:0]  c1_q  [4];
  logic signed [CW-1:0]  c2_q  [4];
  logic [3:0]            rot_q;

  // global advance: move unless a finished result is held back
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;
  assign in_xfer    = in_valid_i & in_ready_o;

  assign a_in[0] = first_x_i;
  assign a_in[1] = first_y_i;
  assign a_in[2] = first_z_i;
  assign a_in[3] = first_w_i;

  // rotation treats the second operand as a pure vector
  assign b_in[0] = second_x_i;
  assign b_in[1] = second_y_i;
  assign b_in[2] = second_z_i;
  assign b_in[3] = func_i ? '0 : second_w_i;

  // second-pass operand: conj(first) for rotation, identity for product
  always_comb begin
    if (func_i) begin
      c_d[0] = -CW'(first_x_i);
      c_d[1] = -CW'(first_y_i);
      c_d[2] = -CW'(first_z_i);
      c_d[3] = CW'(first_w_i);
    end else begin
      c_d[0] = '0;
      c_d[1] = '0;
      c_d[2] = '0;
      c_d[3] = One;
    end
  end

  // side data: c1_q/c2_q follow pass one's two stages, rot_q follows all four
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q  <= c_d;
      c2_q  <= c1_q;
      rot_q <= {rot_q[2:0], func_i};
    end
  end

  qmr_hprod #(
    .FracBits (FracBits),
    .BW       (qmr_pkg::COMP_W)
  ) u_pass1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_xfer),
    .a_i     (a_in),
    .b_i     (b_in),
    .valid_o (v_mid),
    .r_o     (t_mid)
  );

  qmr_hprod #(
    .FracBits (FracBits),
    .BW       (CW)
  ) u_pass2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_mid),
    .a_i     (t_mid),
    .b_i     (c2_q),
    .valid_o (out_valid_o),
    .r_o     (r_out)
  );

  assign out_x_o = r_out[0];
  assign out_y_o = r_out[1];
  assign out_z_o = r_out[2];
  assign out_w_o = rot_q[3] ? '0 : r_out[3];

endmodule

/* hw/rtl/qmr_hprod.sv */
// Two-stage fixed-point Hamilton product with floor truncation and saturation.
module qmr_hprod #(
  parameter int FracBits = qmr_pkg::FRAC_BITS,
  parameter int BW       = qmr_pkg::COMP_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  qmr_pkg::comp_t        a_i [4],
  input  logic signed [BW-1:0]  b_i [4],
  output logic                  valid_o,
  output qmr_pkg::comp_t        r_o [4]
);

  localparam int PW = qmr_pkg::COMP_W + BW;
  localparam int SW = PW - FracBits + 2;
  localparam logic signed [SW-1:0] SatHi = SW'(qmr_pkg::COMP_MAX);
  localparam logic signed [SW-1:0] SatLo = SW'(qmr_pkg::COMP_MIN);

  logic signed [PW-1:0] prod_d [4][4];
  logic signed [PW-1:0] prod_q [4][4];
  logic signed [SW-1:0] acc    [4];
  qmr_pkg::comp_t       r_d    [4];
  qmr_pkg::comp_t       r_q    [4];
  logic                 v1_q, v2_q;

  // stage 1: sixteen exact products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[i][j] = a_i[j] * b_i[qmr_pkg::BSEL[i][j]];
      end
    end
  end

  // stage 2: floor shift, four-term sum, saturate
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (qmr_pkg::BNEG[i][j]) begin
          acc[i] = acc[i] - SW'(prod_q[i][j] >>> FracBits);
        end else begin
          acc[i] = acc[i] + SW'(prod_q[i][j] >>> FracBits);
        end
      end
      if (acc[i] > SatHi) begin
        r_d[i] = qmr_pkg::COMP_MAX;
      end else if (acc[i] < SatLo) begin
        r_d[i] = qmr_pkg::COMP_MIN;
      end else begin
        r_d[i] = acc[i][qmr_pkg::COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      r_q    <= r_d;
    end
  end

  assign valid_o = v2_q;
  assign r_o     = r_q;

endmodule

/* hw/rtl/qmr_checker.sv */
// Port-level checker for the quaternion multiply/rotate unit, with its bind.
`include "assert_macros.svh"

module qmr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               func_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_y_o,
  input logic signed [31:0] out_z_o,
  input logic signed [31:0] out_w_o
);

  logic         out_stall;
  logic [127:0] out_pay;
  logic         xfer_go;
  logic         rot_go;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_pay   = {out_x_o, out_y_o, out_z_o, out_w_o};
  // input transfer with the receiver ready in the same cycle
  assign xfer_go   = in_valid_i && in_ready_o && out_ready_i;
  assign rot_go    = xfer_go && func_i;

  // a stalled result stays presented, payload unchanged
  `QMR_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_pay))

  // input side never blocks while the output is empty
  `QMR_ASSERT(a_ready_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // with no downstream stall, an accepted transfer reaches out_valid_o through both passes
  `QMR_ASSERT(a_latency, clk_i, rst_ni, xfer_go ##1 out_ready_i [*3] |=> out_valid_o)

  // rotation results carry a zero scalar
  `QMR_ASSERT(a_rot_w_zero, clk_i, rst_ni, rot_go ##1 out_ready_i [*3] |=> out_w_o == 32'sd0)

endmodule

bind quaternion_multiply_rotate_unit qmr_checker u_qmr_checker (.*);
